// ===== hdl/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

	// Header layout and CRC constants.
	localparam int unsigned HDR_LEN       = 16;
	localparam int unsigned POS_W         = 5;
	localparam int unsigned CRC_FIELD_POS = 14;
	localparam int unsigned POS_KIND      = 6;
	localparam int unsigned POS_FIDX_HI   = 8;
	localparam int unsigned POS_FIDX_LO   = 9;
	localparam int unsigned POS_FCNT_HI   = 10;
	localparam int unsigned POS_FCNT_LO   = 11;
	localparam int unsigned POS_PAY_HI    = 12;
	localparam int unsigned POS_PAY_LO    = 13;
	localparam int unsigned POS_CRC_HI    = 14;
	localparam int unsigned POS_CRC_LO    = 15;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Queue depth between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_MEDIA  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA  = 8'd3;

	localparam logic [15:0] RST_MAX_PAYLOAD = 16'd1400;
	localparam logic [7:0]  RST_FIRST_FRAME = 8'd0;
	localparam logic [7:0]  RST_LAST_MEDIA  = 8'd2;
	localparam logic [7:0]  RST_FIRST_DATA  = 8'd16;

	// Header check results, first failing check wins.
	typedef enum logic [2:0] {
		HS_OK          = 3'd0,
		HS_FRAG_INDEX  = 3'd1,
		HS_FRAG_COUNT  = 3'd2,
		HS_PAYLOAD     = 3'd3,
		HS_FRAME_TYPE  = 3'd4
	} pcc_status_t;

	// Which header field a byte lands in.
	typedef enum logic [3:0] {
		FLD_NONE,
		FLD_KIND,
		FLD_FIDX_HI,
		FLD_FIDX_LO,
		FLD_FCNT_HI,
		FLD_FCNT_LO,
		FLD_PAY_HI,
		FLD_PAY_LO,
		FLD_CRC_HI,
		FLD_CRC_LO
	} pcc_field_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} pcc_in_t;

	typedef struct packed {
		logic [15:0] computed_crc;
		logic        crc_match;
		logic        short_header;
		logic [2:0]  header_status;
	} pcc_out_t;

	// A classified byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       feed_crc;
		logic       hdr_done;
		pcc_field_t field_sel;
	} pcc_item_t;

	typedef struct packed {
		logic [15:0] max_payload_bytes;
		logic [7:0]  first_frame_type;
		logic [7:0]  last_media_type;
		logic [7:0]  first_data_type;
	} pcc_cfg_t;

	// One byte step of CRC-16-CCITT, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hdl/packet_crc_and_header_checker.sv =====
`timescale 1ns / 1ps

// Packet CRC and header checker.
// Bytes enter on the pkt channel (data_byte, last_byte) one per transaction,
// header first (16 bytes, big-endian), then payload. A classifying front end
// tags each byte with its header role and pushes it into a small queue; the
// back end runs CRC-16-CCITT over header bytes 0-13 and the payload, latches
// the header fields and, on the last byte, writes one result to the res
// channel: computed CRC, CRC match, short-header flag and header status.
// Throughput is one byte per cycle while the queue has room; the back end does
// one CRC byte step per byte. When the queue is empty, a last byte passes
// through a queue slot and then the result register before res_valid rises.
// When the receiver stalls, the result register holds its transaction and
// payload bytes keep draining; a last byte waits at the queue head, and
// pkt_ready drops once the queue of QUEUE_DEPTH bytes is full.
// The cfg channel writes registers 0-3 (payload limit, frame type bounds);
// cfg_ready is always high and other indexes are ignored. Reset clears all
// packet state, empties the queue and returns registers to their defaults.
module packet_crc_and_header_checker import pcc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pkt_valid,
	output logic                  pkt_ready,
	input  pcc_in_t               pkt,
	output logic                  res_valid,
	input  logic                  res_ready,
	output pcc_out_t              res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pcc_cfg_t  cfg_q;
	logic      fr_valid;
	logic      fr_ready;
	pcc_item_t fr_item;
	logic      bk_valid;
	logic      bk_ready;
	pcc_item_t bk_item;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_bytes <= RST_MAX_PAYLOAD;
			cfg_q.first_frame_type  <= RST_FIRST_FRAME;
			cfg_q.last_media_type   <= RST_LAST_MEDIA;
			cfg_q.first_data_type   <= RST_FIRST_DATA;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_PAYLOAD: cfg_q.max_payload_bytes <= cfg_data;
				REG_FIRST_FRAME: cfg_q.first_frame_type  <= cfg_data[7:0];
				REG_LAST_MEDIA:  cfg_q.last_media_type   <= cfg_data[7:0];
				REG_FIRST_DATA:  cfg_q.first_data_type   <= cfg_data[7:0];
				default:         ;
			endcase
		end
	end

	// Front end: byte position and classification.
	pcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_valid  (pkt_valid),
		.pkt_ready  (pkt_ready),
		.pkt        (pkt),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	// Queue between front and back.
	pcc_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_item   (bk_item)
	);

	// Back end: CRC, header capture, checks and result register.
	pcc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (bk_valid),
		.item_ready (bk_ready),
		.item       (bk_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

// ===== hdl/pcc_front.sv =====
`timescale 1ns / 1ps

module pcc_front import pcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pkt_valid,
	output logic      pkt_ready,
	input  pcc_in_t   pkt,
	output logic      item_valid,
	input  logic      item_ready,
	output pcc_item_t item
);

	logic [POS_W-1:0] pos_q;
	logic             accept;

	assign accept     = pkt_valid && item_ready;
	assign pkt_ready  = item_ready;
	assign item_valid = pkt_valid;

	// Byte position within the packet, saturating once the header is complete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (pkt.last_byte) begin
				pos_q <= '0;
			end else if (pos_q < POS_W'(HDR_LEN)) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Classify the byte by its position.
	always_comb begin
		item.data_byte = pkt.data_byte;
		item.last_byte = pkt.last_byte;
		item.feed_crc  = (pos_q < POS_W'(CRC_FIELD_POS)) || (pos_q >= POS_W'(HDR_LEN));
		item.hdr_done  = (pos_q >= POS_W'(HDR_LEN - 1));
		unique case (pos_q)
			POS_W'(POS_KIND):    item.field_sel = FLD_KIND;
			POS_W'(POS_FIDX_HI): item.field_sel = FLD_FIDX_HI;
			POS_W'(POS_FIDX_LO): item.field_sel = FLD_FIDX_LO;
			POS_W'(POS_FCNT_HI): item.field_sel = FLD_FCNT_HI;
			POS_W'(POS_FCNT_LO): item.field_sel = FLD_FCNT_LO;
			POS_W'(POS_PAY_HI):  item.field_sel = FLD_PAY_HI;
			POS_W'(POS_PAY_LO):  item.field_sel = FLD_PAY_LO;
			POS_W'(POS_CRC_HI):  item.field_sel = FLD_CRC_HI;
			POS_W'(POS_CRC_LO):  item.field_sel = FLD_CRC_LO;
			default:             item.field_sel = FLD_NONE;
		endcase
	end

endmodule

// ===== hdl/pcc_queue.sv =====
`timescale 1ns / 1ps

module pcc_queue import pcc_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  pcc_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output pcc_item_t pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pcc_item_t        slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 || count_q == CNT_W'(DEPTH) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hdl/pcc_back.sv =====
`timescale 1ns / 1ps

module pcc_back import pcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pcc_cfg_t  cfg,
	input  logic      item_valid,
	output logic      item_ready,
	input  pcc_item_t item,
	output logic      res_valid,
	input  logic      res_ready,
	output pcc_out_t  res
);

	logic [15:0] crc_q;
	logic [15:0] stored_q;
	logic [15:0] fidx_q;
	logic [15:0] fcnt_q;
	logic [15:0] pay_q;
	logic [7:0]  kind_q;
	logic        res_valid_q;
	pcc_out_t    res_q;

	logic [15:0] crc_n;
	logic [15:0] stored_n;
	logic [15:0] fidx_n;
	logic [15:0] fcnt_n;
	logic [15:0] pay_n;
	logic [7:0]  kind_n;
	pcc_status_t status;
	logic        pop;

	// A last byte needs room in the result register; other bytes always drain.
	assign item_ready = !item.last_byte || !res_valid_q || res_ready;
	assign pop        = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// CRC step and header field capture for the byte at the queue head.
	always_comb begin
		crc_n    = item.feed_crc ? crc_byte(crc_q, item.data_byte) : crc_q;
		stored_n = stored_q;
		fidx_n   = fidx_q;
		fcnt_n   = fcnt_q;
		pay_n    = pay_q;
		kind_n   = kind_q;
		case (item.field_sel)
			FLD_KIND:    kind_n   = item.data_byte;
			FLD_FIDX_HI: fidx_n   = {item.data_byte, fidx_q[7:0]};
			FLD_FIDX_LO: fidx_n   = {fidx_q[15:8], item.data_byte};
			FLD_FCNT_HI: fcnt_n   = {item.data_byte, fcnt_q[7:0]};
			FLD_FCNT_LO: fcnt_n   = {fcnt_q[15:8], item.data_byte};
			FLD_PAY_HI:  pay_n    = {item.data_byte, pay_q[7:0]};
			FLD_PAY_LO:  pay_n    = {pay_q[15:8], item.data_byte};
			FLD_CRC_HI:  stored_n = {item.data_byte, stored_q[7:0]};
			FLD_CRC_LO:  stored_n = {stored_q[15:8], item.data_byte};
			default:     ;
		endcase
	end

	// Header checks in priority order.
	always_comb begin
		if (fidx_n >= fcnt_n) begin
			status = HS_FRAG_INDEX;
		end else if (fcnt_n == '0) begin
			status = HS_FRAG_COUNT;
		end else if (pay_n > cfg.max_payload_bytes) begin
			status = HS_PAYLOAD;
		end else if (kind_n < cfg.first_frame_type ||
				(kind_n > cfg.last_media_type && kind_n < cfg.first_data_type)) begin
			status = HS_FRAME_TYPE;
		end else begin
			status = HS_OK;
		end
	end

	// Packet state; cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			stored_q <= '0;
			fidx_q   <= '0;
			fcnt_q   <= '0;
			pay_q    <= '0;
			kind_q   <= '0;
		end else if (pop) begin
			if (item.last_byte) begin
				crc_q    <= CRC_INIT;
				stored_q <= '0;
				fidx_q   <= '0;
				fcnt_q   <= '0;
				pay_q    <= '0;
				kind_q   <= '0;
			end else begin
				crc_q    <= crc_n;
				stored_q <= stored_n;
				fidx_q   <= fidx_n;
				fcnt_q   <= fcnt_n;
				pay_q    <= pay_n;
				kind_q   <= kind_n;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && item.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop && item.last_byte) begin
			res_q.computed_crc  <= crc_n;
			res_q.crc_match     <= item.hdr_done && (crc_n == stored_n);
			res_q.short_header  <= !item.hdr_done;
			res_q.header_status <= status;
		end
	end

`ifndef SYNTH
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.last_byte |=> crc_q == CRC_INIT && fcnt_q == '0 && stored_q == '0)
		else $error("packet state not cleared after last byte");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |-> !(pop && item.last_byte))
		else $error("pending result overwritten");
	a_short_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.short_header |-> !res_q.crc_match)
		else $error("short header reported a CRC match");
`endif

endmodule

// ===== tb/packet_crc_and_header_checker_tb.sv =====
`timescale 1ns / 1ps

module packet_crc_and_header_checker_tb;
	import pcc_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 40;

	// Indexes outside the register map; the block must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pkt_valid = 1'b0;
	logic                  pkt_ready;
	pcc_in_t               pkt = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	pcc_out_t              res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	packet_crc_and_header_checker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Bytes waiting to be sent, and packet reports still owed by the block.
	pcc_in_t  byte_stream [$];
	pcc_out_t awaited_reports [$];

	logic steady = 1'b0;
	logic pkt_taken = 1'b0;
	int   bytes_queued = 0;
	int   bytes_accepted = 0;
	int   reports_checked = 0;
	int   short_seen = 0;
	int   match_seen = 0;
	int   status_seen [8];
	int   settings_run = 1;
	int   mismatches = 0;
	int   quiet_cycles = 0;

	// Checker copy of the registers.
	logic [15:0] lim_payload = RST_MAX_PAYLOAD;
	logic [7:0]  lim_first_frame = RST_FIRST_FRAME;
	logic [7:0]  lim_last_media = RST_LAST_MEDIA;
	logic [7:0]  lim_first_data = RST_FIRST_DATA;

	// Checker copy of the per-packet state.
	logic [15:0] run_crc = CRC_INIT;
	logic [4:0]  hdr_pos = '0;
	logic [15:0] crc_field = '0;
	logic [15:0] frag_idx = '0;
	logic [15:0] frag_cnt = '0;
	logic [15:0] pay_size = '0;
	logic [7:0]  frame_code = '0;

	// CRC-16-CCITT over one byte, most significant bit first.
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
		end
		return acc;
	endfunction

	// First failing header check wins.
	function automatic pcc_status_t judge_header();
		if (frag_idx >= frag_cnt) return HS_FRAG_INDEX;
		if (frag_cnt == 16'd0) return HS_FRAG_COUNT;
		if (pay_size > lim_payload) return HS_PAYLOAD;
		if (frame_code < lim_first_frame ||
			(frame_code > lim_last_media && frame_code < lim_first_data)) return HS_FRAME_TYPE;
		return HS_OK;
	endfunction

	// Advance the packet state by one accepted byte; a last byte owes a report.
	task automatic absorb_byte(input pcc_in_t b);
		pcc_out_t r;
		if (hdr_pos < 5'(CRC_FIELD_POS) || hdr_pos >= 5'(HDR_LEN)) begin
			run_crc = crc16_next(run_crc, b.data_byte);
		end
		case (hdr_pos)
			5'(POS_KIND):    frame_code = b.data_byte;
			5'(POS_FIDX_HI): frag_idx[15:8] = b.data_byte;
			5'(POS_FIDX_LO): frag_idx[7:0] = b.data_byte;
			5'(POS_FCNT_HI): frag_cnt[15:8] = b.data_byte;
			5'(POS_FCNT_LO): frag_cnt[7:0] = b.data_byte;
			5'(POS_PAY_HI):  pay_size[15:8] = b.data_byte;
			5'(POS_PAY_LO):  pay_size[7:0] = b.data_byte;
			5'(POS_CRC_HI):  crc_field[15:8] = b.data_byte;
			5'(POS_CRC_LO):  crc_field[7:0] = b.data_byte;
			default: ;
		endcase
		if (hdr_pos < 5'(HDR_LEN)) begin
			hdr_pos = hdr_pos + 5'd1;
		end
		if (b.last_byte) begin
			r.computed_crc = run_crc;
			r.short_header = (hdr_pos < 5'(HDR_LEN));
			r.crc_match = !r.short_header && (run_crc == crc_field);
			r.header_status = judge_header();
			awaited_reports.push_back(r);
			run_crc = CRC_INIT;
			hdr_pos = '0;
			crc_field = '0;
			frag_idx = '0;
			frag_cnt = '0;
			pay_size = '0;
			frame_code = '0;
		end
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_MAX_PAYLOAD: lim_payload = d;
			REG_FIRST_FRAME: lim_first_frame = d[7:0];
			REG_LAST_MEDIA:  lim_last_media = d[7:0];
			REG_FIRST_DATA:  lim_first_data = d[7:0];
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT) begin
			$display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	task automatic check_report(input pcc_out_t got);
		pcc_out_t want;
		if (awaited_reports.size() == 0) begin
			report_mismatch("report with none outstanding", 32'(got.computed_crc), 32'd0);
			return;
		end
		want = awaited_reports.pop_front();
		reports_checked++;
		short_seen += int'(want.short_header);
		match_seen += int'(want.crc_match);
		status_seen[want.header_status]++;
		if (got.computed_crc !== want.computed_crc)
			report_mismatch("computed_crc", 32'(got.computed_crc), 32'(want.computed_crc));
		if (got.crc_match !== want.crc_match)
			report_mismatch("crc_match", 32'(got.crc_match), 32'(want.crc_match));
		if (got.short_header !== want.short_header)
			report_mismatch("short_header", 32'(got.short_header), 32'(want.short_header));
		if (got.header_status !== want.header_status)
			report_mismatch("header_status", 32'(got.header_status),
				32'(want.header_status));
	endtask

	// Monitor: sample every transaction at the rising edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			pkt_taken <= 1'b0;
		end else begin
			pkt_taken <= pkt_valid && pkt_ready;
			if (res_valid && res_ready) begin
				check_report(res);
			end
			if (pkt_valid && pkt_ready) begin
				bytes_accepted++;
				absorb_byte(pkt);
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
			end
		end
	end

	// Driver: present the next byte at the falling edge, with random gaps unless steady is set.
	always @(negedge clk) begin
		if (!arst_n) begin
			pkt_valid <= 1'b0;
		end else if (!pkt_valid || pkt_taken) begin
			if (byte_stream.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
				pkt <= byte_stream.pop_front();
				pkt_valid <= 1'b1;
			end else begin
				pkt_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// Watchdog: give up when no transaction of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (pkt_valid && pkt_ready) || (res_valid && res_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Build one packet: header fields as given, random filler and payload, stored CRC
	// correct unless bad_crc. A nonzero cut_len ends the packet after that many bytes.
	task automatic queue_packet(input logic [7:0] ftype, input logic [15:0] fidx,
			input logic [15:0] fcnt, input logic [15:0] psize, input int pay_len,
			input bit bad_crc, input int cut_len);
		logic [7:0]  hdr_bytes [$];
		logic [15:0] c;
		pcc_in_t     item;
		int          n;
		for (int i = 0; i < HDR_LEN + pay_len; i++) begin
			hdr_bytes.push_back(8'($urandom));
		end
		hdr_bytes[POS_KIND] = ftype;
		hdr_bytes[POS_FIDX_HI] = fidx[15:8];
		hdr_bytes[POS_FIDX_LO] = fidx[7:0];
		hdr_bytes[POS_FCNT_HI] = fcnt[15:8];
		hdr_bytes[POS_FCNT_LO] = fcnt[7:0];
		hdr_bytes[POS_PAY_HI] = psize[15:8];
		hdr_bytes[POS_PAY_LO] = psize[7:0];
		c = CRC_INIT;
		for (int i = 0; i < hdr_bytes.size(); i++) begin
			if (i < CRC_FIELD_POS || i >= HDR_LEN) c = crc16_next(c, hdr_bytes[i]);
		end
		if (bad_crc) begin
			c = c ^ (16'd1 << $urandom_range(15));
		end
		hdr_bytes[POS_CRC_HI] = c[15:8];
		hdr_bytes[POS_CRC_LO] = c[7:0];
		n = (cut_len > 0) ? cut_len : hdr_bytes.size();
		for (int i = 0; i < n; i++) begin
			item.data_byte = hdr_bytes[i];
			item.last_byte = (i == n - 1);
			byte_stream.push_back(item);
			bytes_queued++;
		end
	endtask

	// Frame type and payload size are aimed at the edges of the current register settings.
	task automatic queue_random_packet();
		logic [7:0]  ft;
		logic [15:0] fc;
		logic [15:0] fi;
		logic [15:0] ps;
		int          shape;
		int          plen;
		shape = $urandom_range(99);
		case ($urandom_range(6))
			0: ft = lim_first_frame - 8'd1;
			1: ft = lim_first_frame;
			2: ft = lim_last_media;
			3: ft = lim_last_media + 8'd1;
			4: ft = lim_first_data - 8'd1;
			5: ft = lim_first_data;
			default: ft = 8'($urandom);
		endcase
		case ($urandom_range(7))
			0: fc = 16'd0;
			1: fc = 16'($urandom);
			default: fc = 16'($urandom_range(1, 8));
		endcase
		if (fc != 16'd0 && $urandom_range(5) != 0) begin
			fi = 16'($urandom_range(fc - 1));
		end else begin
			fi = $urandom_range(1) ? fc : 16'($urandom);
		end
		case ($urandom_range(4))
			0: ps = lim_payload;
			1: ps = lim_payload + 16'd1;
			2: ps = 16'($urandom_range(lim_payload));
			3: ps = 16'($urandom);
			default: ps = 16'd0;
		endcase
		plen = ($urandom_range(19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
		if (shape < 75) begin
			queue_packet(ft, fi, fc, ps, plen, $urandom_range(5) == 0, 0);
		end else if (shape < 88) begin
			// Header cut short.
			queue_packet(ft, fi, fc, ps, plen, 1'b0, $urandom_range(1, HDR_LEN - 1));
		end else begin
			// Noise: random fields, random CRC, random length.
			queue_packet(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), plen,
				1'($urandom_range(1)), $urandom_range(1, HDR_LEN + plen));
		end
	endtask

	// Wait until every byte is taken and every report has arrived, then let the
	// pipeline settle before touching the registers.
	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || awaited_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int n_bytes);
		int target;
		target = bytes_queued + n_bytes;
		while (bytes_queued < target) begin
			queue_random_packet();
		end
		wait_drained();
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic finish_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_run++;
	endtask

	// Stimulus sequence.
	initial begin
		logic [7:0] lo_type;
		logic [7:0] mid_type;
		foreach (status_seen[s]) status_seen[s] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a one-byte packet, a clean header with no payload, and a header
		// cut right after the frame type.
		queue_packet(8'hFF, 16'h0000, 16'h0000, 16'h0000, 0, 1'b0, 1);
		queue_packet(RST_LAST_MEDIA, 16'h00FE, 16'hFFFF, RST_MAX_PAYLOAD, 0, 1'b0, 0);
		queue_packet(8'hFF, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 1'b0, POS_KIND + 1);
		wait_drained();
		run_random(230);

		// All limits at their lowest, plus a write the block must ignore.
		write_register(REG_MAX_PAYLOAD, 16'd0);
		write_register(REG_FIRST_FRAME, 16'hFF00);
		write_register(REG_LAST_MEDIA, 16'h0000);
		write_register(REG_FIRST_DATA, 16'hA500);
		write_register(REG_UNUSED, 16'hFFFF);
		finish_writes();
		run_random(240);

		// All limits at their highest, with junk in the unused upper bits.
		write_register(REG_MAX_PAYLOAD, 16'hFFFF);
		write_register(REG_FIRST_FRAME, 16'h5AFF);
		write_register(REG_LAST_MEDIA, 16'hFFFF);
		write_register(REG_FIRST_DATA, 16'h00FF);
		finish_writes();
		run_random(220);

		// Random but ordered type ranges, run without any idling on either side.
		lo_type = 8'($urandom_range(0, 40));
		mid_type = lo_type + 8'($urandom_range(0, 20));
		steady = 1'b1;
		write_register(REG_MAX_PAYLOAD, 16'($urandom_range(0, 3000)));
		write_register(REG_FIRST_FRAME, {8'($urandom), lo_type});
		write_register(REG_LAST_MEDIA, {8'($urandom), mid_type});
		write_register(REG_FIRST_DATA, {8'($urandom), mid_type + 8'($urandom_range(0, 40))});
		finish_writes();
		run_random(240);
		steady = 1'b0;

		// Back to the reset values.
		write_register(REG_TOP_INDEX, 16'h1234);
		write_register(REG_MAX_PAYLOAD, RST_MAX_PAYLOAD);
		write_register(REG_FIRST_FRAME, {8'h00, RST_FIRST_FRAME});
		write_register(REG_LAST_MEDIA, {8'h00, RST_LAST_MEDIA});
		write_register(REG_FIRST_DATA, {8'h00, RST_FIRST_DATA});
		finish_writes();
		run_random(240);

		$display("Checked %0d packet reports from %0d bytes over %0d register settings;",
			reports_checked, bytes_accepted, settings_run);
		$display("%0d short headers, %0d CRC matches, status ok/idx/cnt/size/type %0d/%0d/%0d/%0d/%0d.",
			short_seen, match_seen, status_seen[HS_OK], status_seen[HS_FRAG_INDEX],
			status_seen[HS_FRAG_COUNT], status_seen[HS_PAYLOAD], status_seen[HS_FRAME_TYPE]);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/pcc_pkg.sv
hdl/pcc_front.sv
hdl/pcc_queue.sv
hdl/pcc_back.sv
hdl/packet_crc_and_header_checker.sv
tb/packet_crc_and_header_checker_tb.sv
